// ----- rtl/core/fdsr_pkg.sv -----
// Package for the fan duty step regulator: payload types, controller interface, scalings.
`default_nettype none
package fdsr_pkg;

   localparam logic [21:0] RPM_NUMERATOR = 22'd2156220;
   localparam int          DIV_STEPS     = 22;
   localparam int          DIV_CNT_W     = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam logic [7:0] MANUAL_MIN = 8'd10;
   localparam logic [7:0] MANUAL_MAX = 8'd100;

   // ceil(2^19/100) and ceil(2^23/255) reciprocals, exact over the value ranges used
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam logic [15:0] RECIP_255 = 16'd32897;

   typedef struct packed {
      logic [7:0] manual_duty;
      logic       sample_valid;
      logic [7:0] cpu_celsius;
      logic [7:0] gpu_celsius;
      logic [7:0] duty_code;
      logic [7:0] rpm_high;
      logic [7:0] rpm_low;
   } req_type;

   typedef struct packed {
      logic        manual_write;
      logic        manual_rejected;
      logic [7:0]  manual_write_value;
      logic        auto_write;
      logic [6:0]  auto_duty_percent;
      logic [7:0]  auto_write_value;
      logic [6:0]  duty_percent;
      logic [21:0] fan_rpm;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_last;
   } sts_type;

   // floor(pct * 255 / 100)
   function automatic logic [7:0] pct_to_byte(input logic [6:0] pct);
      logic [14:0] scaled;
      logic [27:0] prod;
      begin
         scaled = {pct, 8'b0} - {8'b0, pct};
         prod   = {13'b0, scaled} * {15'b0, RECIP_100};
         return prod[26:19];
      end
   endfunction

   // floor(raw * 100 / 255)
   function automatic logic [6:0] raw_to_pct(input logic [7:0] raw);
      logic [14:0] scaled;
      logic [30:0] prod;
      begin
         scaled = {1'b0, raw, 6'b0} + {2'b0, raw, 5'b0} + {5'b0, raw, 2'b0};
         prod   = {16'b0, scaled} * {15'b0, RECIP_255};
         return prod[29:23];
      end
   endfunction

   // stepped curve with hysteresis; 0 means no step applies
   function automatic logic [6:0] curve_pick(input logic [7:0] temp, input logic [6:0] duty);
      logic [6:0] pick;
      logic       hit;
      begin
         pick = 7'd0;
         hit  = 1'b0;
         for (int k = 0; k < 8; k++) begin
            if (!hit && temp >= 8'(80 - 10 * k) && duty < 7'(100 - 10 * k)) begin
               pick = 7'(100 - 10 * k);
               hit  = 1'b1;
            end
         end
         for (int k = 0; k < 7; k++) begin
            if (!hit && temp <= 8'(15 + 10 * k) && duty > 7'(30 + 10 * k)) begin
               pick = 7'(30 + 10 * k);
               hit  = 1'b1;
            end
         end
         return pick;
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fdsr_ctrl.sv -----
// Controller state machine: sequences load, update, rpm division and result handoff.
`default_nettype none
module fdsr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire fdsr_pkg::sts_type sts,
   output fdsr_pkg::cmd_type     cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = sts.div_needed ? S_DIV : S_FIN;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/fdsr_dp.sv -----
// Datapath: tick state, manual check, sample scaling, bit-serial rpm divider, duty curve.
`default_nettype none
module fdsr_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fdsr_pkg::req_type req_data,
   input  wire logic              csr_write,
   input  wire logic              csr_data,
   input  wire fdsr_pkg::cmd_type cmd,
   output fdsr_pkg::sts_type      sts,
   output fdsr_pkg::rsp_type      rsp_data
);

   fdsr_pkg::req_type req_ff, req_in;
   fdsr_pkg::rsp_type rsp_ff, rsp_in;

   logic        auto_en_ff, auto_en_in;
   logic [7:0]  cpu_ff, cpu_in;
   logic [7:0]  gpu_ff, gpu_in;
   logic [6:0]  duty_ff, duty_in;
   logic [21:0] rpm_ff, rpm_in;
   logic [6:0]  last_auto_ff, last_auto_in;
   logic [7:0]  last_manual_ff, last_manual_in;
   logic        m_wr_ff, m_wr_in;
   logic        m_rej_ff, m_rej_in;
   logic [7:0]  m_val_ff, m_val_in;
   logic [15:0] rem_ff, rem_in;
   logic [21:0] quo_ff, quo_in;
   logic [fdsr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [15:0] count;
   logic [16:0] rem_sh;
   logic        fits;
   logic [7:0]  hot;
   logic [6:0]  pick;
   logic        auto_wr;

   assign count    = {req_ff.rpm_high, req_ff.rpm_low};
   assign rem_sh   = {rem_ff, quo_ff[21]};
   assign fits     = (rem_sh >= {1'b0, count});
   assign hot      = (cpu_ff > gpu_ff) ? cpu_ff : gpu_ff;
   assign pick     = auto_en_ff ? fdsr_pkg::curve_pick(hot, duty_ff) : 7'd0;
   assign auto_wr  = (pick != 7'd0) && (pick != last_auto_ff);

   assign sts.div_needed = req_ff.sample_valid && (count != 16'd0);
   assign sts.div_last   = (cnt_ff == fdsr_pkg::DIV_LAST);
   assign rsp_data       = rsp_ff;

   always_comb begin
      req_in         = cmd.load ? req_data : req_ff;
      auto_en_in     = csr_write ? csr_data : auto_en_ff;
      cpu_in         = cpu_ff;
      gpu_in         = gpu_ff;
      duty_in        = duty_ff;
      rpm_in         = rpm_ff;
      last_auto_in   = last_auto_ff;
      last_manual_in = last_manual_ff;
      m_wr_in        = m_wr_ff;
      m_rej_in       = m_rej_ff;
      m_val_in       = m_val_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_in         = rsp_ff;

      if (cmd.calc) begin
         m_wr_in  = 1'b0;
         m_rej_in = 1'b0;
         m_val_in = 8'd0;
         if (req_ff.manual_duty != 8'd0 && req_ff.manual_duty != last_manual_ff) begin
            if (req_ff.manual_duty >= fdsr_pkg::MANUAL_MIN &&
                req_ff.manual_duty <= fdsr_pkg::MANUAL_MAX) begin
               m_wr_in  = 1'b1;
               m_val_in = fdsr_pkg::pct_to_byte(req_ff.manual_duty[6:0]);
            end else begin
               m_rej_in = 1'b1;
            end
            last_manual_in = req_ff.manual_duty;
         end
         if (req_ff.sample_valid) begin
            cpu_in  = req_ff.cpu_celsius;
            gpu_in  = req_ff.gpu_celsius;
            duty_in = fdsr_pkg::raw_to_pct(req_ff.duty_code);
            if (count == 16'd0) begin
               rpm_in = 22'd0;
            end
         end
         rem_in = 16'd0;
         quo_in = fdsr_pkg::RPM_NUMERATOR;
         cnt_in = '0;
      end

      if (cmd.step) begin
         rem_in = fits ? 16'(rem_sh - {1'b0, count}) : rem_sh[15:0];
         quo_in = {quo_ff[20:0], fits};
         cnt_in = cnt_ff + {{(fdsr_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
         if (sts.div_last) begin
            rpm_in = {quo_ff[20:0], fits};
         end
      end

      if (cmd.finish) begin
         rsp_in.manual_write       = m_wr_ff;
         rsp_in.manual_rejected    = m_rej_ff;
         rsp_in.manual_write_value = m_val_ff;
         rsp_in.auto_write         = auto_wr;
         rsp_in.auto_duty_percent  = pick;
         rsp_in.auto_write_value   = auto_wr ? fdsr_pkg::pct_to_byte(pick) : 8'd0;
         rsp_in.duty_percent       = duty_ff;
         rsp_in.fan_rpm            = rpm_ff;
         if (auto_wr) begin
            last_auto_in = pick;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      m_wr_ff  <= m_wr_in;
      m_rej_ff <= m_rej_in;
      m_val_ff <= m_val_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         auto_en_ff     <= 1'b1;
         cpu_ff         <= 8'd0;
         gpu_ff         <= 8'd0;
         duty_ff        <= 7'd0;
         rpm_ff         <= 22'd0;
         last_auto_ff   <= 7'd0;
         last_manual_ff <= 8'd0;
      end else begin
         auto_en_ff     <= auto_en_in;
         cpu_ff         <= cpu_in;
         gpu_ff         <= gpu_in;
         duty_ff        <= duty_in;
         rpm_ff         <= rpm_in;
         last_auto_ff   <= last_auto_in;
         last_manual_ff <= last_manual_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/fan_duty_step_regulator.sv -----
// Top level of the fan duty step regulator: controller plus datapath.
//
//   channel   prefix  direction  transfer moves
//   request   req_    in         one polling tick (manual request, sensor sample)
//   response  rsp_    out        one result per tick (writes, stored duty, rpm)
//   control   csr_    in         auto_enable bit
//
// The result is registered once the controller has passed its calc and finish states,
// and the divide state in between when a valid sample has a nonzero tachometer count:
// the rpm quotient comes from a restoring divider that produces one bit per cycle.
// The next request can transfer in the same cycle that the result becomes valid.
// Synchronous active-high reset; auto_enable resets to 1, all tick state to 0.
// The result sits in an output register, so a stalled rsp_ready only holds the
// finished tick; the next request transfer waits for the current one to finish.
`default_nettype none
module fan_duty_step_regulator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fdsr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fdsr_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data
);

   fdsr_pkg::cmd_type cmd;
   fdsr_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   fdsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fdsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- rtl/core/fdsr_checker.sv -----
// Port-level checker for the fan duty step regulator, bound to the top level.
`default_nettype none
module fdsr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire fdsr_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed or dropped while stalled");

   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a tick is in progress");

   a_manual_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.manual_write && rsp_data.manual_rejected) &&
                    (rsp_data.manual_write || rsp_data.manual_write_value == 8'd0))
      else $error("inconsistent manual result");

   a_auto_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.auto_write ? rsp_data.auto_duty_percent != 7'd0
                                         : rsp_data.auto_write_value == 8'd0))
      else $error("inconsistent automatic result");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind fan_duty_step_regulator fdsr_checker u_fdsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ----- verif/tb_fan_duty_step_regulator.sv -----
// Self-checking testbench for fan_duty_step_regulator: directed table, then random ticks.
module tb_fan_duty_step_regulator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TACH_NUM  = 2156220;
   localparam int unsigned PCT_LO    = 10;
   localparam int unsigned PCT_HI    = 100;
   localparam int unsigned RUN_LIMIT = 400000;
   localparam int          PLAN_LEN  = 21;

   typedef struct packed {
      bit                is_csr;
      bit                csr_val;
      bit                pinned;
      fdsr_pkg::req_type tick;
      fdsr_pkg::rsp_type want;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fdsr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fdsr_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_data = 1'b0;

   // pinned expectation travels alongside the request payload
   bit                req_pinned = 1'b0;
   fdsr_pkg::rsp_type req_pinned_rsp = '0;

   bit                idling_on = 1'b1;
   int unsigned       rsp_hold_left = 0;
   int unsigned       cycle_cnt = 0;
   int unsigned       mismatch_cnt = 0;
   int unsigned       ticks_seen = 0;
   fdsr_pkg::rsp_type tick_results_q[$];

   // predictor state
   bit          auto_on = 1'b1;
   logic [7:0]  cur_cpu_celsius = '0;
   logic [7:0]  cur_gpu_celsius = '0;
   logic [6:0]  cur_duty_pct = '0;
   logic [21:0] cur_rpm = '0;
   logic [6:0]  prev_auto_pct = '0;
   logic [7:0]  prev_manual_pct = '0;

   // stimulus shaping
   logic [7:0]  last_manual_sent = '0;
   int          drift_cpu = 40;
   int          drift_gpu = 40;

   plan_row_type plan [PLAN_LEN] = '{
      '{1'b0, 1'b0, 1'b1, '{0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{1'b0, 1'b0, 1'b1, '{10, 1, 0, 0, 0, 0, 0}, '{1, 0, 25, 0, 0, 0, 0, 0}},
      '{1'b0, 1'b0, 1'b1, '{100, 1, 255, 0, 255, 0, 1},
                          '{1, 0, 255, 0, 0, 0, 100, 2156220}},
      '{1'b0, 1'b0, 1'b1, '{100, 1, 80, 0, 0, 255, 255}, '{0, 0, 0, 1, 100, 255, 0, 32}},
      '{1'b0, 1'b0, 1'b1, '{9, 0, 0, 0, 0, 0, 0}, '{0, 1, 0, 0, 100, 0, 0, 32}},
      '{1'b0, 1'b0, 1'b1, '{101, 1, 0, 0, 255, 0, 0}, '{0, 1, 0, 1, 30, 76, 100, 0}},
      '{1'b0, 1'b0, 1'b1, '{255, 0, 0, 0, 0, 0, 0}, '{0, 1, 0, 0, 30, 0, 100, 0}},
      '{1'b0, 1'b0, 1'b1, '{255, 1, 0, 80, 0, 0, 0}, '{0, 0, 0, 1, 100, 255, 0, 0}},
      '{1'b1, 1'b0, 1'b0, '0, '0},
      '{1'b0, 1'b0, 1'b0, '{50, 1, 255, 255, 128, 1, 0}, '0},
      '{1'b0, 1'b0, 1'b0, '{50, 0, 8'hAA, 8'h55, 0, 0, 0}, '0},
      '{1'b1, 1'b1, 1'b0, '0, '0},
      '{1'b0, 1'b0, 1'b0, '{0, 1, 79, 10, 227, 8'h12, 8'h34}, '0},
      '{1'b0, 1'b0, 1'b0, '{0, 1, 10, 0, 0, 8'hFF, 8'h00}, '0},
      '{1'b0, 1'b0, 1'b0, '{0, 1, 15, 15, 255, 8'h00, 8'hFF}, '0},
      '{1'b0, 1'b0, 1'b0, '{0, 1, 16, 9, 255, 8'h80, 8'h01}, '0},
      '{1'b0, 1'b0, 1'b0, '{0, 1, 75, 75, 254, 8'h01, 8'h00}, '0},
      '{1'b0, 1'b0, 1'b0, '{99, 1, 255, 255, 255, 0, 2}, '0},
      '{1'b0, 1'b0, 1'b0, '{0, 1, 8'h5A, 8'hA5, 8'hAA, 8'h55, 8'hAA}, '0},
      '{1'b0, 1'b0, 1'b0, '{0, 0, 8'hA5, 8'h5A, 8'h55, 8'hAA, 8'h55}, '0},
      '{1'b0, 1'b0, 1'b0, '{10, 1, 0, 0, 0, 0, 0}, '0}
   };

   fan_duty_step_regulator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stepped curve: rising step at level-20 degrees, falling step at level-15 degrees
   function automatic logic [6:0] step_curve(input logic [7:0] temp, input logic [6:0] duty);
      int lvl;
      for (lvl = 100; lvl >= 30; lvl -= 10)
         if (int'(temp) >= lvl - 20 && int'(duty) < lvl) return 7'(lvl);
      for (lvl = 30; lvl <= 90; lvl += 10)
         if (int'(temp) <= lvl - 15 && int'(duty) > lvl) return 7'(lvl);
      return 7'd0;
   endfunction

   function automatic fdsr_pkg::rsp_type regulate_tick(input fdsr_pkg::req_type r);
      fdsr_pkg::rsp_type o;
      int unsigned       count;
      logic [7:0]        hot;
      o = '0;
      count = {r.rpm_high, r.rpm_low};
      if (r.manual_duty != 0 && r.manual_duty != prev_manual_pct) begin
         if (r.manual_duty >= PCT_LO && r.manual_duty <= PCT_HI) begin
            o.manual_write       = 1'b1;
            o.manual_write_value = 8'(int'(r.manual_duty) * 255 / 100);
         end else begin
            o.manual_rejected = 1'b1;
         end
         prev_manual_pct = r.manual_duty;
      end
      if (r.sample_valid) begin
         cur_cpu_celsius = r.cpu_celsius;
         cur_gpu_celsius = r.gpu_celsius;
         cur_duty_pct    = 7'(int'(r.duty_code) * 100 / 255);
         cur_rpm         = (count == 0) ? 22'd0 : 22'(TACH_NUM / count);
      end
      if (auto_on) begin
         hot = (cur_cpu_celsius > cur_gpu_celsius) ? cur_cpu_celsius : cur_gpu_celsius;
         o.auto_duty_percent = step_curve(hot, cur_duty_pct);
         if (o.auto_duty_percent != 0 && o.auto_duty_percent != prev_auto_pct) begin
            o.auto_write       = 1'b1;
            o.auto_write_value = 8'(int'(o.auto_duty_percent) * 255 / 100);
            prev_auto_pct      = o.auto_duty_percent;
         end
      end
      o.duty_percent = cur_duty_pct;
      o.fan_rpm      = cur_rpm;
      return o;
   endfunction

   task automatic flag_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatch_cnt++;
         if (mismatch_cnt <= 10)
            $display("tick %0d %s: expected %0d, got %0d", ticks_seen, name, want, got);
      end
   endtask

   task automatic check_tick(input fdsr_pkg::rsp_type want, input fdsr_pkg::rsp_type got);
      flag_field("manual_write", want.manual_write, got.manual_write);
      flag_field("manual_rejected", want.manual_rejected, got.manual_rejected);
      flag_field("manual_write_value", want.manual_write_value, got.manual_write_value);
      flag_field("auto_write", want.auto_write, got.auto_write);
      flag_field("auto_duty_percent", want.auto_duty_percent, got.auto_duty_percent);
      flag_field("auto_write_value", want.auto_write_value, got.auto_write_value);
      flag_field("duty_percent", want.duty_percent, got.duty_percent);
      flag_field("fan_rpm", want.fan_rpm, got.fan_rpm);
   endtask

   always @(posedge clock) begin : monitor
      fdsr_pkg::rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) auto_on = csr_data;
         if (req_valid && req_ready) begin
            want = regulate_tick(req_data);
            if (req_pinned) want = req_pinned_rsp;
            tick_results_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (tick_results_q.size() == 0) begin
               flag_field("result transfers pending", 0, 1);
            end else begin
               check_tick(tick_results_q.pop_front(), rsp_data);
            end
            ticks_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == RUN_LIMIT) begin
         $display("fan_duty_step_regulator: mismatch");
         $finish;
      end
   end

   // result side: random stalls plus a long hold-off when requested
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ready <= !idling_on || ($urandom_range(99) >= 22);
      end
   end

   function automatic int drift_temp(input int prev);
      int t;
      t = prev + $urandom_range(16) - 8;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return t;
   endfunction

   function automatic fdsr_pkg::req_type random_tick();
      fdsr_pkg::req_type t;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 45) t.manual_duty = 8'd0;
      else if (pick < 65) t.manual_duty = last_manual_sent;
      else if (pick < 90) t.manual_duty = 8'($urandom_range(PCT_HI, PCT_LO));
      else t.manual_duty = 8'($urandom_range(255));
      if (t.manual_duty != 0) last_manual_sent = t.manual_duty;
      t.sample_valid = ($urandom_range(99) < 85);
      if ($urandom_range(99) < 30) begin
         drift_cpu = $urandom_range(255);
         drift_gpu = $urandom_range(255);
      end else begin
         drift_cpu = drift_temp(drift_cpu);
         drift_gpu = drift_temp(drift_gpu);
      end
      t.cpu_celsius = 8'(drift_cpu);
      t.gpu_celsius = 8'(drift_gpu);
      t.duty_code   = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
         t.rpm_high = 8'd0;
         t.rpm_low  = 8'd0;
      end else begin
         t.rpm_high = 8'($urandom_range(255));
         t.rpm_low  = 8'($urandom_range(255));
      end
      return t;
   endfunction

   task automatic send_tick(input fdsr_pkg::req_type item, input bit pin,
                            input fdsr_pkg::rsp_type pin_rsp);
      while (idling_on && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data       <= item;
      req_pinned     <= pin;
      req_pinned_rsp <= pin_rsp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // withdraw the already transferred request, then wait for every result
   task automatic await_drain();
      req_valid <= 1'b0;
      while (tick_results_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_auto_enable(input bit value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            await_drain();
            write_auto_enable(plan[i].csr_val);
         end else begin
            send_tick(plan[i].tick, plan[i].pinned, plan[i].want);
         end
      end

      // phase 1 runs without idling, phase 2 opens with a long result stall,
      // phase 3 pauses the sender until all results are back
      for (int ph = 0; ph < 6; ph++) begin
         await_drain();
         write_auto_enable(ph == 2 ? 1'($urandom_range(1)) : (ph % 3 != 0));
         idling_on = (ph != 1);
         if (ph == 2) rsp_hold_left = 400;
         for (int n = 0; n < 155; n++) begin
            if (ph == 3 && n % 40 == 39) await_drain();
            send_tick(random_tick(), 1'b0, '0);
         end
      end

      await_drain();
      repeat (40) @(posedge clock);
      if (mismatch_cnt == 0 && tick_results_q.size() == 0) begin
         $display("fan_duty_step_regulator: match");
      end else begin
         $display("fan_duty_step_regulator: mismatch");
      end
      $finish;
   end

endmodule
